FILE: rtl/ldd_pkg.sv
// Shared constants, types and codes of the lock wait-for deadlock detector.
// No dependencies; every other file of the block refers to this package.
package ldd_pkg;

	localparam int MAX_THREADS = 64;
	localparam int MAX_LOCKS   = 64;
	localparam int ID_W        = 64;
	localparam int TIDX_W      = $clog2(MAX_THREADS);
	localparam int TCNT_W      = $clog2(MAX_THREADS + 1);
	localparam int LIDX_W      = $clog2(MAX_LOCKS);
	localparam int LCNT_W      = $clog2(MAX_LOCKS + 1);
	localparam int WAIT_W      = 7;
	localparam logic [WAIT_W-1:0] WAITER_MAX = 7'd127;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	typedef enum logic [1:0] {
		OP_REQUEST = 2'd0,
		OP_ACQUIRE = 2'd1,
		OP_RELEASE = 2'd2,
		OP_CHECK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_THREAD_FULL = 2'd1,
		ST_LOCK_FULL   = 2'd2,
		ST_UNKNOWN     = 2'd3
	} status_t;

	typedef struct packed {
		op_t             op;
		logic [ID_W-1:0] tid;
		logic [ID_W-1:0] addr;
	} item_t;

	// one saved depth-first stack frame
	typedef struct packed {
		logic [TIDX_W-1:0] node;
		logic [TCNT_W-1:0] next;
	} frame_t;

endpackage

FILE: rtl/ldd_if.sv
// Handshake channels of the detector: lock events in, results out.
// Depends on ldd_pkg for field widths.
interface ldd_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  operation;
	logic [ldd_pkg::ID_W-1:0]    thread_id;
	logic [ldd_pkg::ID_W-1:0]    lock_addr;
	modport source (output valid, operation, thread_id, lock_addr, input ready);
	modport sink (input valid, operation, thread_id, lock_addr, output ready);
endinterface

interface ldd_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic                        deadlock_found;
	logic [ldd_pkg::ID_W-1:0]    cycle_thread;
	modport source (output valid, status, deadlock_found, cycle_thread, input ready);
	modport sink (input valid, status, deadlock_found, cycle_thread, output ready);
endinterface

FILE: rtl/ldd_front.sv
// Front end: accepts lock events, decodes the operation, queues them.
// Depends on ldd_pkg and ldd_req_if.
module ldd_front (
	input  logic          clk,
	input  logic          arst_n,
	ldd_req_if.sink       req,
	output logic          item_valid,
	input  logic          item_ready,
	output ldd_pkg::item_t item
);

	ldd_pkg::item_t                fifo_mem [ldd_pkg::FIFO_DEPTH];
	logic [ldd_pkg::FIFO_AW-1:0]   wr_ptr_q;
	logic [ldd_pkg::FIFO_AW-1:0]   rd_ptr_q;
	logic [ldd_pkg::FIFO_AW:0]     cnt_q;
	logic                          push;
	logic                          pop;
	ldd_pkg::item_t                in_item;

	assign req.ready  = (cnt_q != (ldd_pkg::FIFO_AW+1)'(ldd_pkg::FIFO_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign push       = req.valid && req.ready;
	assign pop        = item_valid && item_ready;
	assign item       = fifo_mem[rd_ptr_q];

	// classify the raw operation code
	always_comb begin
		in_item.op   = ldd_pkg::op_t'(req.operation);
		in_item.tid  = req.thread_id;
		in_item.addr = req.lock_addr;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (!push && pop) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: rtl/ldd_engine.sv
// Back end: table searches, lock/edge updates and the depth-first cycle search.
// Depends on ldd_pkg and ldd_rsp_if.
module ldd_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  ldd_pkg::item_t item,
	ldd_rsp_if.source      rsp
);

	localparam int TIDX_W = ldd_pkg::TIDX_W;
	localparam int TCNT_W = ldd_pkg::TCNT_W;
	localparam int LIDX_W = ldd_pkg::LIDX_W;
	localparam int LCNT_W = ldd_pkg::LCNT_W;
	localparam int NT     = ldd_pkg::MAX_THREADS;
	localparam int NL     = ldd_pkg::MAX_LOCKS;

	typedef enum logic [4:0] {
		S_IDLE, S_LK_RD, S_LK_CMP, S_LK_DONE, S_TH_RD, S_TH_CMP, S_TH_DONE,
		S_LD_RD, S_LD_WT, S_ROW_RD, S_ROW_WR, S_D_SEED, S_D_ROW_RD, S_D_ROW_LD,
		S_D_SCAN, S_D_POP_WT, S_D_WHO_RD, S_D_WHO_WT, S_OUT
	} state_t;

	state_t                state_q;
	ldd_pkg::item_t        item_q;
	logic [LCNT_W-1:0]     lidx_q;
	logic [TCNT_W-1:0]     tidx_q;
	logic [LIDX_W-1:0]     slot_q;
	logic                  slot_hit_q;
	logic [LIDX_W-1:0]     free_q;
	logic                  free_hit_q;
	logic [TIDX_W-1:0]     t_q;
	logic [TIDX_W-1:0]     owner_q;
	logic [TCNT_W-1:0]     thread_count_q;
	logic [NL-1:0]         lock_valid_q;
	logic [NT-1:0]         row_valid_q;
	logic [NT-1:0]         visited_q;
	logic [NT-1:0]         onpath_q;
	logic [NT-1:0]         row_q;
	logic [TCNT_W-1:0]     s_q;
	logic [TCNT_W-1:0]     j_q;
	logic [TCNT_W-1:0]     sp_q;
	logic [TIDX_W-1:0]     top_q;
	logic                  out_valid_q;
	ldd_pkg::status_t      status_q;
	logic                  found_q;
	logic [ldd_pkg::ID_W-1:0] who_q;

	// memories
	logic [ldd_pkg::ID_W-1:0]  lock_addr_mem [NL];
	logic [TIDX_W-1:0]         owner_mem [NL];
	logic [ldd_pkg::WAIT_W-1:0] wcnt_mem [NL];
	logic [ldd_pkg::ID_W-1:0]  tid_mem [NT];
	logic [NT-1:0]             row_mem [NT];
	ldd_pkg::frame_t           stack_mem [NT];

	logic [ldd_pkg::ID_W-1:0]  la_rdata;
	logic [TIDX_W-1:0]         own_rdata;
	logic [ldd_pkg::WAIT_W-1:0] wc_rdata;
	logic [ldd_pkg::ID_W-1:0]  tid_rdata;
	logic [NT-1:0]             row_rdata;
	ldd_pkg::frame_t           stk_rdata;

	// memory control
	logic                  la_re, la_we;
	logic                  ld_re;
	logic                  own_we, wc_we;
	logic [LIDX_W-1:0]     own_waddr;
	logic [TIDX_W-1:0]     own_wdata;
	logic [ldd_pkg::WAIT_W-1:0] wc_wdata;
	logic                  tid_re, tid_we;
	logic [TIDX_W-1:0]     tid_raddr;
	logic                  row_re, row_we;
	logic [TIDX_W-1:0]     row_raddr;
	logic [NT-1:0]         row_wdata;
	logic                  stk_re, stk_we;
	ldd_pkg::frame_t       stk_wdata;

	// decision terms
	logic [LIDX_W-1:0]     lidx;
	logic                  lk_end;
	logic                  th_end;
	logic                  th_full;
	logic [TIDX_W-1:0]     jj;
	logic                  j_in;
	logic                  edge_hit;
	logic                  can_push;
	logic [TCNT_W-1:0]     sp_m1;
	logic [TCNT_W-1:0]     sp_m2;
	logic [ldd_pkg::WAIT_W-1:0] wc_inc;
	logic [ldd_pkg::WAIT_W-1:0] wc_dec;
	logic [NT-1:0]         row_cur;
	logic [NT-1:0]         owner_bit;
	logic                  new_lock;

	assign lidx     = lidx_q[LIDX_W-1:0];
	assign lk_end   = (lidx_q == LCNT_W'(NL));
	assign th_end   = (tidx_q == thread_count_q);
	assign th_full  = (thread_count_q == TCNT_W'(NT));
	assign jj       = j_q[TIDX_W-1:0];
	assign j_in     = (j_q < thread_count_q);
	assign edge_hit = j_in && row_q[jj];
	assign can_push = !visited_q[jj] && (sp_q < TCNT_W'(NT));
	assign sp_m1    = sp_q - 1'b1;
	assign sp_m2    = sp_q - 2'd2;
	assign wc_inc   = (wc_rdata < ldd_pkg::WAITER_MAX) ? wc_rdata + 1'b1 : wc_rdata;
	assign wc_dec   = (wc_rdata != '0) ? wc_rdata - 1'b1 : wc_rdata;
	assign row_cur  = row_valid_q[t_q] ? row_rdata : '0;
	assign owner_bit = NT'(1) << owner_q;
	assign new_lock = (item_q.op == ldd_pkg::OP_ACQUIRE) && !slot_hit_q;

	assign item_ready         = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.deadlock_found = found_q;
	assign rsp.cycle_thread   = who_q;

	// memory port steering
	always_comb begin
		la_re     = (state_q == S_LK_RD) && !lk_end && lock_valid_q[lidx];
		la_we     = (state_q == S_TH_DONE) && new_lock;
		ld_re     = (state_q == S_LD_RD);
		own_we    = 1'b0;
		own_waddr = slot_q;
		own_wdata = t_q;
		wc_we     = 1'b0;
		wc_wdata  = '0;
		if ((state_q == S_TH_DONE) && new_lock) begin
			own_we    = 1'b1;
			own_waddr = free_q;
			wc_we     = 1'b1;
		end else if (state_q == S_LD_WT) begin
			if (item_q.op == ldd_pkg::OP_REQUEST) begin
				wc_we    = 1'b1;
				wc_wdata = wc_inc;
			end else if (item_q.op == ldd_pkg::OP_ACQUIRE) begin
				wc_we    = 1'b1;
				wc_wdata = wc_dec;
				own_we   = 1'b1;
			end
		end
		tid_re    = ((state_q == S_TH_RD) && !th_end) || (state_q == S_D_WHO_RD);
		tid_raddr = (state_q == S_D_WHO_RD) ? jj : tidx_q[TIDX_W-1:0];
		tid_we    = (state_q == S_TH_RD) && th_end && !th_full;
		row_re    = (state_q == S_ROW_RD) || (state_q == S_D_ROW_RD);
		row_raddr = (state_q == S_ROW_RD) ? t_q : top_q;
		row_we    = (state_q == S_ROW_WR);
		row_wdata = (item_q.op == ldd_pkg::OP_REQUEST) ? (row_cur | owner_bit)
			: (row_cur & ~owner_bit);
		stk_we    = (state_q == S_D_SCAN) && edge_hit && !onpath_q[jj] && can_push;
		stk_wdata.node = top_q;
		stk_wdata.next = j_q + 1'b1;
		stk_re    = (state_q == S_D_SCAN) && !j_in && (sp_q != TCNT_W'(1));
	end

	// lock table memories
	always_ff @(posedge clk) begin
		if (la_re) la_rdata <= lock_addr_mem[lidx];
		if (la_we) lock_addr_mem[free_q] <= item_q.addr;
	end

	always_ff @(posedge clk) begin
		if (ld_re) begin
			own_rdata <= owner_mem[slot_q];
			wc_rdata  <= wcnt_mem[slot_q];
		end
		if (own_we) owner_mem[own_waddr] <= own_wdata;
		if (wc_we) wcnt_mem[own_waddr] <= wc_wdata;
	end

	// thread id table
	always_ff @(posedge clk) begin
		if (tid_re) tid_rdata <= tid_mem[tid_raddr];
		if (tid_we) tid_mem[thread_count_q[TIDX_W-1:0]] <= item_q.tid;
	end

	// wait-for matrix rows
	always_ff @(posedge clk) begin
		if (row_re) row_rdata <= row_mem[row_raddr];
		if (row_we) row_mem[t_q] <= row_wdata;
	end

	// search stack
	always_ff @(posedge clk) begin
		if (stk_re) stk_rdata <= stack_mem[sp_m2[TIDX_W-1:0]];
		if (stk_we) stack_mem[sp_m1[TIDX_W-1:0]] <= stk_wdata;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			thread_count_q <= '0;
			lock_valid_q   <= '0;
			row_valid_q    <= '0;
			visited_q      <= '0;
			onpath_q       <= '0;
			sp_q           <= '0;
			out_valid_q    <= 1'b0;
			status_q       <= ldd_pkg::ST_OK;
			found_q        <= 1'b0;
			who_q          <= '0;
			item_q         <= '0;
			lidx_q         <= '0;
			tidx_q         <= '0;
			slot_q         <= '0;
			slot_hit_q     <= 1'b0;
			free_q         <= '0;
			free_hit_q     <= 1'b0;
			t_q            <= '0;
			owner_q        <= '0;
			row_q          <= '0;
			s_q            <= '0;
			j_q            <= '0;
			top_q          <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						item_q     <= item;
						lidx_q     <= '0;
						slot_hit_q <= 1'b0;
						free_hit_q <= 1'b0;
						status_q   <= ldd_pkg::ST_OK;
						found_q    <= 1'b0;
						who_q      <= '0;
						if (item.op == ldd_pkg::OP_CHECK) begin
							visited_q <= '0;
							onpath_q  <= '0;
							sp_q      <= '0;
							s_q       <= '0;
							state_q   <= S_D_SEED;
						end else begin
							state_q <= S_LK_RD;
						end
					end
				end
				// lock table search, lowest free slot on the way
				S_LK_RD: begin
					if (lk_end) begin
						state_q <= S_LK_DONE;
					end else if (!lock_valid_q[lidx]) begin
						if (!free_hit_q) begin
							free_q     <= lidx;
							free_hit_q <= 1'b1;
						end
						lidx_q <= lidx_q + 1'b1;
					end else begin
						state_q <= S_LK_CMP;
					end
				end
				S_LK_CMP: begin
					if (la_rdata == item_q.addr) begin
						slot_q     <= lidx;
						slot_hit_q <= 1'b1;
						state_q    <= S_LK_DONE;
					end else begin
						lidx_q  <= lidx_q + 1'b1;
						state_q <= S_LK_RD;
					end
				end
				S_LK_DONE: begin
					tidx_q <= '0;
					case (item_q.op)
						ldd_pkg::OP_REQUEST: begin
							if (slot_hit_q) state_q <= S_TH_RD;
							else begin
								out_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end
						end
						ldd_pkg::OP_ACQUIRE: begin
							if (slot_hit_q || free_hit_q) state_q <= S_TH_RD;
							else begin
								status_q    <= ldd_pkg::ST_LOCK_FULL;
								out_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end
						end
						ldd_pkg::OP_RELEASE: begin
							if (slot_hit_q) state_q <= S_LD_RD;
							else begin
								status_q    <= ldd_pkg::ST_UNKNOWN;
								out_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end
						end
						default: begin
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end
					endcase
				end
				// thread lookup, register on a miss
				S_TH_RD: begin
					if (th_end) begin
						if (th_full) begin
							status_q    <= ldd_pkg::ST_THREAD_FULL;
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							t_q            <= thread_count_q[TIDX_W-1:0];
							thread_count_q <= thread_count_q + 1'b1;
							state_q        <= S_TH_DONE;
						end
					end else begin
						state_q <= S_TH_CMP;
					end
				end
				S_TH_CMP: begin
					if (tid_rdata == item_q.tid) begin
						t_q     <= tidx_q[TIDX_W-1:0];
						state_q <= S_TH_DONE;
					end else begin
						tidx_q  <= tidx_q + 1'b1;
						state_q <= S_TH_RD;
					end
				end
				S_TH_DONE: begin
					if (new_lock) begin
						lock_valid_q[free_q] <= 1'b1;
						out_valid_q          <= 1'b1;
						state_q              <= S_OUT;
					end else begin
						state_q <= S_LD_RD;
					end
				end
				S_LD_RD: state_q <= S_LD_WT;
				S_LD_WT: begin
					owner_q <= own_rdata;
					case (item_q.op)
						ldd_pkg::OP_RELEASE: begin
							if (wc_rdata == '0) lock_valid_q[slot_q] <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end
						ldd_pkg::OP_REQUEST: begin
							if (t_q != own_rdata) state_q <= S_ROW_RD;
							else begin
								out_valid_q <= 1'b1;
								state_q     <= S_OUT;
							end
						end
						default: state_q <= S_ROW_RD;
					endcase
				end
				S_ROW_RD: state_q <= S_ROW_WR;
				S_ROW_WR: begin
					row_valid_q[t_q] <= 1'b1;
					out_valid_q      <= 1'b1;
					state_q          <= S_OUT;
				end
				// depth-first search, one root at a time
				S_D_SEED: begin
					if (s_q == thread_count_q) begin
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else if (visited_q[s_q[TIDX_W-1:0]]) begin
						s_q <= s_q + 1'b1;
					end else begin
						top_q                        <= s_q[TIDX_W-1:0];
						j_q                          <= '0;
						sp_q                         <= TCNT_W'(1);
						visited_q[s_q[TIDX_W-1:0]]   <= 1'b1;
						onpath_q[s_q[TIDX_W-1:0]]    <= 1'b1;
						state_q                      <= S_D_ROW_RD;
					end
				end
				S_D_ROW_RD: state_q <= S_D_ROW_LD;
				S_D_ROW_LD: begin
					row_q   <= row_valid_q[top_q] ? row_rdata : '0;
					state_q <= S_D_SCAN;
				end
				// one neighbor per cycle
				S_D_SCAN: begin
					if (j_in) begin
						if (edge_hit && onpath_q[jj]) begin
							state_q <= S_D_WHO_RD;
						end else if (edge_hit && can_push) begin
							visited_q[jj] <= 1'b1;
							onpath_q[jj]  <= 1'b1;
							top_q         <= jj;
							j_q           <= '0;
							sp_q          <= sp_q + 1'b1;
							state_q       <= S_D_ROW_RD;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						onpath_q[top_q] <= 1'b0;
						sp_q            <= sp_m1;
						if (sp_q == TCNT_W'(1)) begin
							s_q     <= s_q + 1'b1;
							state_q <= S_D_SEED;
						end else begin
							state_q <= S_D_POP_WT;
						end
					end
				end
				S_D_POP_WT: begin
					top_q   <= stk_rdata.node;
					j_q     <= stk_rdata.next;
					state_q <= S_D_ROW_RD;
				end
				S_D_WHO_RD: state_q <= S_D_WHO_WT;
				S_D_WHO_WT: begin
					found_q     <= 1'b1;
					who_q       <= tid_rdata;
					out_valid_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_onpath_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(onpath_q & ~visited_q) == '0)
		else $error("on-path thread not marked visited");
	a_thread_bound: assert property (@(posedge clk) disable iff (!arst_n)
		thread_count_q <= TCNT_W'(NT))
		else $error("thread count beyond table");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= thread_count_q)
		else $error("search stack deeper than thread count");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> status_q == ldd_pkg::ST_OK)
		else $error("cycle reported with error status");
	a_lock_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && status_q == ldd_pkg::ST_LOCK_FULL |-> &lock_valid_q)
		else $error("lock table full reported with a free slot");
`endif

endmodule

FILE: rtl/lock_wait_for_deadlock_detector.sv
// Lock wait-for deadlock detector, top level: front queue plus back engine.
// A lock event scans the lock table and then, for a request on a known lock or an acquire that finds
// or can add its lock, the thread table; a check searches depth-first from each thread not yet visited.
// One item is worked at a time; a four-deep queue keeps accepting while a result waits, until it is full.
// Reset (arst_n, async): clears thread count, lock valid bits and wait-for row valid bits.
// Depends on ldd_pkg, ldd_if, ldd_front and ldd_engine.
module lock_wait_for_deadlock_detector (
	input  logic      clk,
	input  logic      arst_n,
	ldd_req_if.sink   req,
	ldd_rsp_if.source rsp
);

	logic           item_valid;
	logic           item_ready;
	ldd_pkg::item_t item;

	ldd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	ldd_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.rsp        (rsp)
	);

endmodule

FILE: tb/tb_lock_wait_for_deadlock_detector.sv
// Testbench of the lock wait-for deadlock detector: directed table, random lock traffic, waiter
// saturation, full tables; results checked against the in-bench wait-for graph predictor or typed rows.
// Depends on ldd_pkg, ldd_if and lock_wait_for_deadlock_detector.
`timescale 1ns / 1ps

module tb_lock_wait_for_deadlock_detector;

	localparam int ID_W        = ldd_pkg::ID_W;
	localparam int MAX_THREADS = ldd_pkg::MAX_THREADS;
	localparam int MAX_LOCKS   = ldd_pkg::MAX_LOCKS;

	typedef struct {
		ldd_pkg::status_t status;
		bit               found;
		logic [ID_W-1:0]  who;
	} rsp_t;

	typedef struct {
		ldd_pkg::op_t    op;
		logic [ID_W-1:0] tid;
		logic [ID_W-1:0] addr;
		bit              typed;
		rsp_t            rsp;
	} row_t;

	localparam logic [ID_W-1:0] ONES = {ID_W{1'b1}};
	localparam logic [ID_W-1:0] ZERO = '0;

	logic clk;
	logic arst_n;
	bit   failed;
	int   burst_left;

	ldd_req_if req ();
	ldd_rsp_if rsp ();

	lock_wait_for_deadlock_detector i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// predictor state: thread table, lock table, wait-for matrix
	logic [ID_W-1:0]   thread_tab[MAX_THREADS];
	int                thread_cnt;
	logic [ID_W-1:0]   lock_addr_tab[MAX_LOCKS];
	bit                lock_live[MAX_LOCKS];
	int                lock_owner[MAX_LOCKS];
	int                lock_waiters[MAX_LOCKS];
	bit [MAX_THREADS-1:0] waits_for[MAX_THREADS];

	rsp_t expected_rsp_q[$];

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int lookup_lock(logic [ID_W-1:0] addr);
		for (int i = 0; i < MAX_LOCKS; i++)
			if (lock_live[i] && lock_addr_tab[i] == addr) return i;
		return -1;
	endfunction

	function automatic int lookup_thread(logic [ID_W-1:0] id);
		for (int i = 0; i < thread_cnt; i++)
			if (thread_tab[i] == id) return i;
		return -1;
	endfunction

	function automatic int enroll_thread(logic [ID_W-1:0] id);
		int t;
		t = lookup_thread(id);
		if (t >= 0) return t;
		if (thread_cnt >= MAX_THREADS) return -1;
		thread_tab[thread_cnt] = id;
		thread_cnt++;
		return thread_cnt - 1;
	endfunction

	function automatic int live_locks();
		int c;
		c = 0;
		foreach (lock_live[i]) c += lock_live[i];
		return c;
	endfunction

	// depth-first walk; only an edge back onto the current path is a cycle
	function automatic bit walk_for_cycle(output logic [ID_W-1:0] who);
		int node[MAX_THREADS];
		int nxt[MAX_THREADS];
		bit seen[MAX_THREADS];
		bit on_path[MAX_THREADS];
		int n, sp, top, j;
		n = thread_cnt;
		who = '0;
		foreach (seen[i]) begin
			seen[i] = 0;
			on_path[i] = 0;
		end
		for (int s = 0; s < n; s++) begin
			if (seen[s]) continue;
			node[0] = s;
			nxt[0] = 0;
			sp = 1;
			seen[s] = 1;
			on_path[s] = 1;
			while (sp > 0) begin
				top = node[sp-1];
				j = nxt[sp-1];
				while (j < n && !waits_for[top][j]) j++;
				if (j < n) begin
					nxt[sp-1] = j + 1;
					if (on_path[j]) begin
						who = thread_tab[j];
						return 1;
					end
					if (!seen[j] && sp < MAX_THREADS) begin
						seen[j] = 1;
						on_path[j] = 1;
						node[sp] = j;
						nxt[sp] = 0;
						sp++;
					end
				end else begin
					on_path[top] = 0;
					sp--;
				end
			end
		end
		return 0;
	endfunction

	// apply one lock event to the predicted graph and return the expected result
	function automatic rsp_t model_lock_event(ldd_pkg::op_t op, logic [ID_W-1:0] tid,
			logic [ID_W-1:0] addr);
		rsp_t r;
		int slot, t, own, e;
		r.status = ldd_pkg::ST_OK;
		r.found = 0;
		r.who = '0;
		slot = lookup_lock(addr);
		case (op)
			ldd_pkg::OP_REQUEST: begin
				if (slot >= 0) begin
					t = enroll_thread(tid);
					if (t < 0) begin
						r.status = ldd_pkg::ST_THREAD_FULL;
					end else begin
						own = lock_owner[slot];
						if (lock_waiters[slot] < ldd_pkg::WAITER_MAX) lock_waiters[slot]++;
						if (t != own) waits_for[t][own] = 1'b1;
					end
				end
			end
			ldd_pkg::OP_ACQUIRE: begin
				if (slot >= 0) begin
					t = enroll_thread(tid);
					if (t < 0) begin
						r.status = ldd_pkg::ST_THREAD_FULL;
					end else begin
						own = lock_owner[slot];
						if (lock_waiters[slot] > 0) lock_waiters[slot]--;
						waits_for[t][own] = 1'b0;
						lock_owner[slot] = t;
					end
				end else begin
					e = -1;
					for (int i = 0; i < MAX_LOCKS; i++)
						if (!lock_live[i]) begin
							e = i;
							break;
						end
					if (e < 0) begin
						r.status = ldd_pkg::ST_LOCK_FULL;
					end else begin
						t = enroll_thread(tid);
						if (t < 0) begin
							r.status = ldd_pkg::ST_THREAD_FULL;
						end else begin
							lock_live[e] = 1;
							lock_addr_tab[e] = addr;
							lock_owner[e] = t;
							lock_waiters[e] = 0;
						end
					end
				end
			end
			ldd_pkg::OP_RELEASE: begin
				if (slot < 0) r.status = ldd_pkg::ST_UNKNOWN;
				else if (lock_waiters[slot] == 0) lock_live[slot] = 0;
			end
			default: begin
				r.found = walk_for_cycle(r.who);
			end
		endcase
		return r;
	endfunction

	// one transfer on the event channel, with bursts and random gaps
	task automatic send_event(ldd_pkg::op_t op, logic [ID_W-1:0] tid, logic [ID_W-1:0] addr,
			bit typed = 0, rsp_t typed_rsp = '{ldd_pkg::ST_OK, 0, '0});
		int gap;
		rsp_t r;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.thread_id <= tid;
		req.lock_addr <= addr;
		do @(posedge clk); while (!req.ready);
		r = model_lock_event(op, tid, addr);
		expected_rsp_q.push_back(typed ? typed_rsp : r);
		burst_left--;
	endtask

	// result side: stall pattern plus field-by-field compare
	int  stall_left;
	bit  stall_mode;
	always @(posedge clk) begin
		rsp_t e;
		if (rsp.valid && rsp.ready) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: result with nothing expected: status %0d found %0b who %h",
					$time, rsp.status, rsp.deadlock_found, rsp.cycle_thread);
				failed = 1;
			end else begin
				e = expected_rsp_q.pop_front();
				if (rsp.status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
					failed = 1;
				end
				if (rsp.deadlock_found !== e.found) begin
					$display("%0t: deadlock_found expected %0b actual %0b", $time, e.found,
						rsp.deadlock_found);
					failed = 1;
				end
				if (rsp.cycle_thread !== e.who) begin
					$display("%0t: cycle_thread expected %h actual %h", $time, e.who,
						rsp.cycle_thread);
					failed = 1;
				end
			end
		end
		if (stall_left <= 0) begin
			stall_mode = $urandom_range(0, 1);
			stall_left = $urandom_range(5, 200);
		end
		stall_left--;
		rsp.ready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
	end

	// directed table: extremes, every operation, unknown release, a two-thread cycle
	row_t dir_rows[$];

	initial begin
		logic [ID_W-1:0] tpool[8];
		logic [ID_W-1:0] apool[6];
		logic [ID_W-1:0] t, a;
		int  pick, n_items;
		ldd_pkg::op_t op;

		req.valid = 1'b0;
		req.operation = ldd_pkg::OP_REQUEST;
		req.thread_id = '0;
		req.lock_addr = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		failed = 0;
		burst_left = 0;
		stall_left = 0;
		thread_cnt = 0;
		foreach (lock_live[i]) lock_live[i] = 0;
		foreach (waits_for[i]) waits_for[i] = '0;

		dir_rows = '{
			'{ldd_pkg::OP_RELEASE, ZERO, 64'h5,  1, '{ldd_pkg::ST_UNKNOWN, 0, ZERO}},
			'{ldd_pkg::OP_CHECK,   ZERO, ZERO,   1, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_REQUEST, ONES, ONES,   1, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_ACQUIRE, ONES, ZERO,   1, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_REQUEST, 64'h1, ZERO,  0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_ACQUIRE, 64'h1, ONES,  0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_REQUEST, ONES, ONES,   0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_CHECK,   ZERO, ZERO,   1, '{ldd_pkg::ST_OK, 1, ONES}},
			'{ldd_pkg::OP_RELEASE, ZERO, ZERO,   0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_ACQUIRE, 64'h1, ZERO,  0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_CHECK,   ZERO, ZERO,   0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_RELEASE, ONES, ZERO,   0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_RELEASE, ONES, ZERO,   1, '{ldd_pkg::ST_UNKNOWN, 0, ZERO}},
			'{ldd_pkg::OP_REQUEST, ZERO, ONES,   0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_ACQUIRE, ZERO, ONES,   0, '{ldd_pkg::ST_OK, 0, ZERO}},
			'{ldd_pkg::OP_CHECK,   ZERO, ZERO,   0, '{ldd_pkg::ST_OK, 0, ZERO}}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_event(dir_rows[i].op, dir_rows[i].tid, dir_rows[i].addr,
				dir_rows[i].typed, dir_rows[i].rsp);

		// small thread and lock pools so that waits and cycles form often
		tpool[0] = ZERO;
		tpool[1] = ONES;
		apool[0] = ZERO;
		apool[1] = ONES;
		for (int i = 2; i < 8; i++) tpool[i] = {$urandom, $urandom};
		for (int i = 2; i < 6; i++) apool[i] = {$urandom, $urandom};
		for (int k = 0; k < 350; k++) begin
			pick = $urandom_range(0, 99);
			op = pick < 32 ? ldd_pkg::OP_REQUEST : pick < 64 ? ldd_pkg::OP_ACQUIRE
				: pick < 88 ? ldd_pkg::OP_RELEASE : ldd_pkg::OP_CHECK;
			t = ($urandom_range(0, 32) == 0) ? {$urandom, $urandom} : tpool[$urandom_range(0, 7)];
			a = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : apool[$urandom_range(0, 5)];
			send_event(op, t, a);
			// drain: hold the channel idle until every result is back
			if (k == 175) begin
				req.valid <= 1'b0;
				wait (expected_rsp_q.size() == 0);
			end
		end

		// waiter count saturates high, then drains to zero and stays
		send_event(ldd_pkg::OP_ACQUIRE, tpool[2], 64'hA5A5);
		for (int k = 0; k < 130; k++) send_event(ldd_pkg::OP_REQUEST, tpool[3], 64'hA5A5);
		for (int k = 0; k < 130; k++) send_event(ldd_pkg::OP_ACQUIRE, tpool[3], 64'hA5A5);
		send_event(ldd_pkg::OP_RELEASE, tpool[0], 64'hA5A5);

		// fill the lock table, then the thread table, and hit both limits
		while (live_locks() < MAX_LOCKS) begin
			a = {$urandom, $urandom};
			if (lookup_lock(a) >= 0) continue;
			t = (thread_cnt < MAX_THREADS) ? {$urandom, $urandom} : tpool[1];
			send_event(ldd_pkg::OP_ACQUIRE, t, a);
		end
		send_event(ldd_pkg::OP_ACQUIRE, tpool[0], {$urandom, $urandom});
		while (thread_cnt < MAX_THREADS)
			send_event(ldd_pkg::OP_REQUEST, {$urandom, $urandom},
				lock_addr_tab[$urandom_range(0, 63)]);
		send_event(ldd_pkg::OP_REQUEST, {$urandom, $urandom}, lock_addr_tab[0]);
		send_event(ldd_pkg::OP_ACQUIRE, {$urandom, $urandom}, lock_addr_tab[1]);

		// mixed traffic on full tables, checks kept rare since they are slow here
		n_items = 0;
		while (n_items < 60) begin
			pick = $urandom_range(0, 99);
			op = pick < 35 ? ldd_pkg::OP_REQUEST : pick < 70 ? ldd_pkg::OP_ACQUIRE
				: pick < 94 ? ldd_pkg::OP_RELEASE : ldd_pkg::OP_CHECK;
			t = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
				: thread_tab[$urandom_range(0, MAX_THREADS - 1)];
			a = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
				: lock_addr_tab[$urandom_range(0, MAX_LOCKS - 1)];
			send_event(op, t, a);
			n_items++;
		end
		send_event(ldd_pkg::OP_CHECK, ZERO, ZERO);

		req.valid <= 1'b0;
		wait (expected_rsp_q.size() == 0);
		repeat (300) @(posedge clk);
		if (!failed && expected_rsp_q.size() == 0) begin
			$display("tb_lock_wait_for_deadlock_detector: PASS");
		end else begin
			if (expected_rsp_q.size() != 0)
				$display("%0t: %0d results never arrived", $time, expected_rsp_q.size());
			$display("tb_lock_wait_for_deadlock_detector: FAIL");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#200_000_000;
		$display("%0t: timeout, %0d results outstanding", $time, expected_rsp_q.size());
		$display("tb_lock_wait_for_deadlock_detector: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ldd_pkg.sv
rtl/ldd_if.sv
rtl/ldd_front.sv
rtl/ldd_engine.sv
rtl/lock_wait_for_deadlock_detector.sv
tb/tb_lock_wait_for_deadlock_detector.sv
